>>> design/r2c_pkg.sv
// Shared constants for the IPv4 range to CIDR block expander.
`default_nettype none
package r2c_pkg;

    localparam int ADDR_W_DEFAULT = 32;
    localparam int PREFIX_W       = 6;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

>>> design/r2c_front.sv
// Front stage: takes a range, classifies it and computes its address count.
`default_nettype none
module r2c_front #(
    parameter int ADDRESS_WIDTH = r2c_pkg::ADDR_W_DEFAULT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [ADDRESS_WIDTH-1:0] i_start_address,
    input  wire logic [ADDRESS_WIDTH-1:0] i_end_address,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output logic [ADDRESS_WIDTH-1:0]      o_cur,
    output logic [ADDRESS_WIDTH:0]        o_rem
);
    import r2c_pkg::*;

    logic                     r_valid;
    logic [ADDRESS_WIDTH-1:0] r_cur;
    logic [ADDRESS_WIDTH:0]   r_rem;
    logic                     accept;
    logic [ADDRESS_WIDTH:0]   n_rem;

    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_cur  = r_cur;
    assign o_rem  = r_rem;

    // An inverted range becomes a single-address run at the start address.
    always_comb begin
        if (i_start_address > i_end_address) begin
            n_rem = (ADDRESS_WIDTH+1)'(1);
        end else begin
            n_rem = {1'b0, i_end_address} - {1'b0, i_start_address} + (ADDRESS_WIDTH+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= i_start_address;
            r_rem <= n_rem;
        end
    end

endmodule
`default_nettype wire

>>> design/r2c_queue.sv
// Short queue of classified ranges between the front and back stages.
`default_nettype none
module r2c_queue #(
    parameter int ADDRESS_WIDTH = r2c_pkg::ADDR_W_DEFAULT
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire logic [ADDRESS_WIDTH-1:0] i_cur,
    input  wire logic [ADDRESS_WIDTH:0]   i_rem,
    output logic                          o_full,
    input  wire logic                     i_pop,
    output logic                          o_nonempty,
    output logic [ADDRESS_WIDTH-1:0]      o_cur,
    output logic [ADDRESS_WIDTH:0]        o_rem
);
    import r2c_pkg::*;

    logic [ADDRESS_WIDTH-1:0] r_cur_q [QUEUE_DEPTH];
    logic [ADDRESS_WIDTH:0]   r_rem_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        r_wptr;
    logic [QPTR_W-1:0]        r_rptr;
    logic [QCNT_W-1:0]        r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cur      = r_cur_q[r_rptr];
    assign o_rem      = r_rem_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cur_q[r_wptr] <= i_cur;
            r_rem_q[r_wptr] <= i_rem;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

>>> design/r2c_back.sv
// Back stage: walks one range and emits one CIDR block per cycle.
`default_nettype none
module r2c_back #(
    parameter int ADDRESS_WIDTH = r2c_pkg::ADDR_W_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_nonempty,
    input  wire logic [ADDRESS_WIDTH-1:0]   i_cur,
    input  wire logic [ADDRESS_WIDTH:0]     i_rem,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic [ADDRESS_WIDTH-1:0]        o_block_base,
    output logic [r2c_pkg::PREFIX_W-1:0]    o_prefix_length,
    output logic                            o_last_block
);
    import r2c_pkg::*;

    localparam int KW = $clog2(ADDRESS_WIDTH + 1);

    logic                     r_active;
    logic [ADDRESS_WIDTH-1:0] r_cur;
    logic [ADDRESS_WIDTH:0]   r_rem;
    logic                     r_valid;
    logic [ADDRESS_WIDTH-1:0] r_base;
    logic [PREFIX_W-1:0]      r_prefix;
    logic                     r_last;

    logic [KW-1:0]            tz;
    logic [KW-1:0]            msb;
    logic [KW-1:0]            k;
    logic [ADDRESS_WIDTH:0]   blk;
    logic [ADDRESS_WIDTH:0]   n_rem;
    logic [ADDRESS_WIDTH-1:0] n_cur;
    logic                     done;

    // Block size is limited by the alignment of the cursor and by the
    // number of addresses still to cover; take the smaller exponent.
    always_comb begin
        tz = KW'(ADDRESS_WIDTH);
        for (int i = ADDRESS_WIDTH - 1; i >= 0; i--) begin
            if (r_cur[i]) begin
                tz = KW'(i);
            end
        end
        msb = '0;
        for (int j = 0; j <= ADDRESS_WIDTH; j++) begin
            if (r_rem[j]) begin
                msb = KW'(j);
            end
        end
        k     = (tz < msb) ? tz : msb;
        blk   = (ADDRESS_WIDTH+1)'(1) << k;
        n_rem = r_rem - blk;
        n_cur = r_cur + blk[ADDRESS_WIDTH-1:0];
        done  = (n_rem == '0);
    end

    assign o_pop           = !r_active && i_nonempty;
    assign o_valid         = r_valid;
    assign o_block_base    = r_base;
    assign o_prefix_length = r_prefix;
    assign o_last_block    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_cur;
            r_rem <= i_rem;
        end else if (r_active) begin
            r_cur <= n_cur;
            r_rem <= n_rem;
        end
        if (r_active) begin
            r_base   <= r_cur;
            r_prefix <= PREFIX_W'(ADDRESS_WIDTH) - PREFIX_W'(k);
            r_last   <= done;
        end
    end

    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_rem != '0)
        else $error("walk active with nothing left to cover");
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_block) |=> !o_valid)
        else $error("block emitted right after the last of a run");
    a_prefix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_prefix_length <= PREFIX_W'(ADDRESS_WIDTH))
        else $error("prefix length beyond address width");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_active)
        else $error("range loaded but walk not started");

endmodule
`default_nettype wire

>>> design/ipv4_range_to_cidr_blocks_unit.sv
// Top level of the IPv4 range to CIDR block expander.
// A range passes the front stage register, the queue and the walker's cursor register
// before its first block is registered at the output. The back stage walks one range at
// a time, one block per cycle, and pops the next range only once the current one is done.
// start is taken whenever busy is low; busy rises only when the queue and front stage are full.
// Reset clears the stage, queue and walker valid state; no memory needs a clearing pass.
`default_nettype none
module ipv4_range_to_cidr_blocks_unit #(
    parameter int ADDRESS_WIDTH = r2c_pkg::ADDR_W_DEFAULT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [ADDRESS_WIDTH-1:0]   i_start_address,
    input  wire logic [ADDRESS_WIDTH-1:0]   i_end_address,
    output logic                            o_valid,
    output logic [ADDRESS_WIDTH-1:0]        o_block_base,
    output logic [r2c_pkg::PREFIX_W-1:0]    o_prefix_length,
    output logic                            o_last_block
);
    import r2c_pkg::*;

    // The front stage turns each beat into a cursor and an address count.
    // An inverted range is given a count of one, so the walker emits a
    // single full-length block at the start address without a special path.
    logic                     push;
    logic                     q_full;
    logic [ADDRESS_WIDTH-1:0] f_cur;
    logic [ADDRESS_WIDTH:0]   f_rem;

    // Queue head toward the walker.
    logic                     pop;
    logic                     q_nonempty;
    logic [ADDRESS_WIDTH-1:0] q_cur;
    logic [ADDRESS_WIDTH:0]   q_rem;

    r2c_front #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_start_address (i_start_address),
        .i_end_address   (i_end_address),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cur           (f_cur),
        .o_rem           (f_rem)
    );

    // The queue lets the front stage take the next range while the walker
    // is still emitting blocks of the current one.
    r2c_queue #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cur      (f_cur),
        .i_rem      (f_rem),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_cur      (q_cur),
        .o_rem      (q_rem)
    );

    // The walker emits the largest aligned block that fits at the cursor,
    // advances past it, and flags the block that exhausts the count.
    r2c_back #(.ADDRESS_WIDTH(ADDRESS_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (q_nonempty),
        .i_cur           (q_cur),
        .i_rem           (q_rem),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_block_base    (o_block_base),
        .o_prefix_length (o_prefix_length),
        .o_last_block    (o_last_block)
    );

endmodule
`default_nettype wire

>>> verif/ipv4_range_to_cidr_blocks_checker.sv
`timescale 1ns / 1ps
// Scoreboard that predicts and checks the CIDR block runs of the range expander.
module ipv4_range_to_cidr_blocks_checker #(
    parameter int ADDRESS_WIDTH = r2c_pkg::ADDR_W_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    input  wire logic                           busy,
    input  wire logic [ADDRESS_WIDTH-1:0]       i_start_address,
    input  wire logic [ADDRESS_WIDTH-1:0]       i_end_address,
    input  wire logic                           o_valid,
    input  wire logic [ADDRESS_WIDTH-1:0]       o_block_base,
    input  wire logic [r2c_pkg::PREFIX_W-1:0]   o_prefix_length,
    input  wire logic                           o_last_block,
    output int                                  fail_count,
    output int                                  pending_blocks
);
    import r2c_pkg::*;

    localparam logic [ADDRESS_WIDTH:0] ONE = 1;

    typedef struct packed {
        logic [ADDRESS_WIDTH-1:0] base;
        logic [PREFIX_W-1:0]      prefix;
        logic                     last;
    } t_cidr_block;

    t_cidr_block expected_blocks[$];
    int          mismatch_total = 0;
    int          outstanding    = 0;

    assign fail_count     = mismatch_total;
    assign pending_blocks = outstanding;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_total++;
    endtask

    // Adds one predicted block at the tail of the list of blocks still owed.
    task automatic append_block(input logic [ADDRESS_WIDTH-1:0] base,
                                input logic [PREFIX_W-1:0]      prefix,
                                input logic                     last);
        t_cidr_block entry;
        entry.base   = base;
        entry.prefix = prefix;
        entry.last   = last;
        expected_blocks.insert(expected_blocks.size(), entry);
    endtask

    // Walks the range from its start, taking at each step the largest aligned
    // block that stays within the end address. The cursor carries one spare bit
    // so that a block ending at the top of the address space does not wrap.
    task automatic expand_range(input logic [ADDRESS_WIDTH-1:0] first_addr,
                                input logic [ADDRESS_WIDTH-1:0] last_addr);
        logic [ADDRESS_WIDTH:0] cursor;
        logic [ADDRESS_WIDTH:0] span_top;
        logic [ADDRESS_WIDTH:0] size;
        logic [ADDRESS_WIDTH:0] limit;
        int unsigned            order;
        logic                   done;
        if (first_addr > last_addr) begin
            append_block(first_addr, PREFIX_W'(ADDRESS_WIDTH), 1'b1);
        end else begin
            cursor = {1'b0, first_addr};
            limit  = {1'b0, last_addr};
            done   = 1'b0;
            while (!done) begin
                order = 0;
                while (order < ADDRESS_WIDTH) begin
                    size = ONE << (order + 1);
                    if ((cursor & (size - ONE)) != '0) break;
                    if (cursor + size - ONE > limit) break;
                    order++;
                end
                span_top = cursor + (ONE << order) - ONE;
                done     = (span_top >= limit);
                append_block(cursor[ADDRESS_WIDTH-1:0],
                             PREFIX_W'(ADDRESS_WIDTH - order), done);
                cursor = span_top + ONE;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cidr_block got;
        t_cidr_block want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expand_range(i_start_address, i_end_address);
            end
            if (o_valid) begin
                got = '{o_block_base, o_prefix_length, o_last_block};
                if (expected_blocks.size() == 0) begin
                    report_mismatch($sformatf("unexpected block %h/%0d last=%b",
                                              got.base, got.prefix, got.last));
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.base !== want.base) begin
                        report_mismatch($sformatf("block_base %h, want %h",
                                                  got.base, want.base));
                    end
                    if (got.prefix !== want.prefix) begin
                        report_mismatch($sformatf("prefix_length %0d, want %0d at %h",
                                                  got.prefix, want.prefix, want.base));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch($sformatf("last_block %b, want %b at %h",
                                                  got.last, want.last, want.base));
                    end
                end
            end
        end
        outstanding = expected_blocks.size();
    end

endmodule

>>> verif/tb_ipv4_range_to_cidr_blocks_unit.sv
`timescale 1ns / 1ps
// Testbench top for the IPv4 range to CIDR block expander: clock, reset, stimulus, verdict.
module tb_ipv4_range_to_cidr_blocks_unit;
    import r2c_pkg::*;

    localparam int ADDR_W        = ADDR_W_DEFAULT;
    // The slowest legal run is a few hundred ranges of up to 62 blocks each,
    // plus idle gaps; this limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT   = 300000;
    // A short tail after the last expected block is enough to catch any stray extras.
    localparam int DRAIN_CYCLES  = 10;
    localparam int RANDOM_RANGES = 360;
    localparam int IDLE_PHASES   = 4;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ADDR_W-1:0] i_start_address;
    logic [ADDR_W-1:0] i_end_address;
    logic              o_valid;
    logic [ADDR_W-1:0] o_block_base;
    logic [PREFIX_W-1:0] o_prefix_length;
    logic              o_last_block;

    int fail_count;
    int pending_blocks;
    int idle_pct;
    int cycle_count;

    ipv4_range_to_cidr_blocks_unit #(
        .ADDRESS_WIDTH (ADDR_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_start_address (i_start_address),
        .i_end_address   (i_end_address),
        .o_valid         (o_valid),
        .o_block_base    (o_block_base),
        .o_prefix_length (o_prefix_length),
        .o_last_block    (o_last_block)
    );

    // The checker sits beside the block, sees both channels and keeps its own
    // list of the blocks still owed; it reports the failure count back here.
    ipv4_range_to_cidr_blocks_checker #(
        .ADDRESS_WIDTH (ADDR_W)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_start_address (i_start_address),
        .i_end_address   (i_end_address),
        .o_valid         (o_valid),
        .o_block_base    (o_block_base),
        .o_prefix_length (o_prefix_length),
        .o_last_block    (o_last_block),
        .fail_count      (fail_count),
        .pending_blocks  (pending_blocks)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a missing block ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Sends one range beat. The task is entered and left at a falling edge on
    // which start has not been assigned yet, so a back-to-back beat keeps start
    // high without lowering it in the same time step. While the sender idles,
    // the address ports carry junk that the block must ignore.
    task automatic send_range(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi);
        while ($urandom_range(99) < idle_pct) begin
            start           <= 1'b0;
            i_start_address <= $urandom;
            i_end_address   <= $urandom;
            @(negedge i_clk);
        end
        start           <= 1'b1;
        i_start_address <= lo;
        i_end_address   <= hi;
        // The beat is taken at the rising edge where busy is low.
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every block owed has come back. It always
    // waits for a falling edge, even with nothing owed, so that the next
    // beat does not assign start in the same step.
    task automatic drain_pause();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_blocks != 0);
    endtask

    // Builds one random range. The mix leans toward ranges that give long and
    // varied runs, with aligned blocks, short spans, single addresses, ranges
    // near both ends of the address space and inverted ranges mixed in.
    task automatic make_range(output logic [ADDR_W-1:0] lo, output logic [ADDR_W-1:0] hi);
        logic [ADDR_W:0]   span;
        logic [ADDR_W-1:0] swap;
        int unsigned       order;
        order = $urandom_range(ADDR_W);
        span  = ({{ADDR_W{1'b0}}, 1'b1} << order) - 1;
        lo    = $urandom;
        hi    = $urandom;
        case ($urandom_range(9))
            0: begin
                // Left unordered: about half of these start above the end.
            end
            1, 2: begin
                if (lo > hi) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
            end
            3: hi = lo + $urandom_range(300);
            4: begin
                lo = lo & ~span[ADDR_W-1:0];
                hi = lo + span[ADDR_W-1:0];
            end
            5: begin
                lo = (lo & ~span[ADDR_W-1:0]) + $urandom_range(3);
                hi = lo + span[ADDR_W-1:0] - $urandom_range(3);
            end
            6: begin
                lo = $urandom_range(3);
                hi = ~ADDR_W'($urandom_range(3));
            end
            7: hi = lo;
            8: lo = hi + 1 + $urandom_range(50);
            default: begin
                lo = lo >> $urandom_range(ADDR_W - 1);
                hi = hi | (hi << $urandom_range(ADDR_W - 1));
            end
        endcase
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_start_address = '0;
        i_end_address   = '0;
        idle_pct        = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ranges, sent back to back.
        send_range(32'h0000_0000, 32'hFFFF_FFFF);  // whole space, one /0
        send_range(32'h0000_0000, 32'h0000_0000);  // single address at the bottom
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // single address at the top
        send_range(32'h0000_0005, 32'h0000_0004);  // start above end
        send_range(32'hFFFF_FFFF, 32'h0000_0000);  // start above end, extremes
        send_range(32'h0000_0001, 32'hFFFF_FFFE);  // longest possible run
        send_range(32'h0000_0000, 32'hFFFF_FFFE);  // start at zero must not give /0
        send_range(32'h0000_0001, 32'hFFFF_FFFF);
        send_range(32'h0000_0000, 32'h7FFF_FFFF);  // lower half, one /1
        send_range(32'h8000_0000, 32'hFFFF_FFFF);  // upper half, one /1
        send_range(32'h0A00_0000, 32'h0AFF_FFFF);  // one /8
        send_range(32'hC0A8_0001, 32'hC0A8_00FE);
        send_range(32'h1234_5678, 32'h1234_5679);  // one /31
        send_range(32'h0000_0010, 32'h0000_0011);  // one /31
        send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_range(32'h0000_0000, 32'h0000_0001);
        send_range(32'h5555_5555, 32'hAAAA_AAAA);
        send_range(32'hAAAA_AAAA, 32'h5555_5555);  // start above end, alternating bits

        // Random ranges in phases of differing sender idling. Each phase opens
        // with a full drain, so the sender also waits out every owed block.
        for (int phase = 0; phase < IDLE_PHASES; phase++) begin
            drain_pause();
            case (phase)
                0:       idle_pct = 67;
                1:       idle_pct = 0;
                2:       idle_pct = 9;
                default: idle_pct = 67;
            endcase
            for (int n = 0; n < RANDOM_RANGES / IDLE_PHASES; n++) begin
                make_range(lo, hi);
                send_range(lo, hi);
            end
        end

        drain_pause();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_blocks == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
design/r2c_pkg.sv
design/r2c_front.sv
design/r2c_queue.sv
design/r2c_back.sv
design/ipv4_range_to_cidr_blocks_unit.sv
verif/ipv4_range_to_cidr_blocks_checker.sv
verif/tb_ipv4_range_to_cidr_blocks_unit.sv
